// ===== design/ltgi_pkg.sv =====
// Shared types and constants for the transfinite grid interpolator.
`timescale 1ns / 1ps
package ltgi_pkg;

    localparam int IDX_IN_W     = 10;
    localparam int CFG_W        = 11;
    localparam int CFG_IDX_W    = 1;
    localparam int IO_COORD_W   = 32;
    localparam int QBITS        = 16;
    localparam int WBITS        = QBITS + 1;
    localparam int DIV_STAGES   = 4;
    localparam int DIV_BPS      = QBITS / DIV_STAGES;
    localparam int BLEND_STAGES = 4;
    localparam int LAT          = 1 + DIV_STAGES + BLEND_STAGES + 1;

    localparam logic [WBITS-1:0] ONE_Q16 = WBITS'(1) << QBITS;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_INTERP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        ST_LOADED = 2'd0,
        ST_INTERP = 2'd1,
        ST_BAD    = 2'd2,
        ST_SAT    = 2'd3
    } status_t;

    typedef struct packed {
        logic                         req_type;
        logic [IDX_IN_W-1:0]          col_index;
        logic [IDX_IN_W-1:0]          row_index;
        logic signed [IO_COORD_W-1:0] coord_x;
        logic signed [IO_COORD_W-1:0] coord_z;
    } req_t;

    typedef struct packed {
        logic signed [IO_COORD_W-1:0] out_x;
        logic signed [IO_COORD_W-1:0] out_z;
        status_t                      status;
    } rsp_t;

    typedef struct packed {
        logic interp;
        logic bad;
    } ctl_t;

endpackage

// ===== design/ltgi_ram.sv =====
// Edge store: one write port, one registered read port.
`timescale 1ns / 1ps
module ltgi_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DWID  = 64
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  logic [DWID-1:0] wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output logic [DWID-1:0] rdata
);

    logic [DWID-1:0] mem [DEPTH];
    logic [DWID-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ltgi_div.sv =====
// Pipelined restoring divider for the Q0.16 interpolation weight.
`timescale 1ns / 1ps
module ltgi_div #(
    parameter int DW = 11
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [DW-1:0]              num,
    input  logic [DW-1:0]              den,
    output logic [ltgi_pkg::QBITS-1:0] quo
);

    localparam int NS  = ltgi_pkg::DIV_STAGES;
    localparam int BPS = ltgi_pkg::DIV_BPS;
    localparam int QB  = ltgi_pkg::QBITS;

    logic [DW-1:0] rem_in   [NS];
    logic [QB-1:0] quo_in   [NS];
    logic [DW-1:0] rem_next [NS];
    logic [QB-1:0] quo_next [NS];
    logic [DW-1:0] rem_reg  [NS];
    logic [QB-1:0] quo_reg  [NS];

    assign rem_in[0] = num;
    assign quo_in[0] = '0;

    for (genvar g = 0; g < NS; g++)
    begin : g_stage
        if (g > 0)
        begin : g_link
            assign rem_in[g] = rem_reg[g-1];
            assign quo_in[g] = quo_reg[g-1];
        end

        // numerator starts as index*2^16 with index < den, so the remainder
        // begins at the index and one quotient bit falls out per step
        always_comb
        begin
            logic [DW:0]   r2;
            logic [DW-1:0] r;
            logic [QB-1:0] q;
            r = rem_in[g];
            q = quo_in[g];
            for (int b = 0; b < BPS; b++)
            begin
                r2 = {r, 1'b0};
                if (r2 >= {1'b0, den})
                begin
                    r2 = r2 - {1'b0, den};
                    q  = {q[QB-2:0], 1'b1};
                end
                else
                begin
                    q  = {q[QB-2:0], 1'b0};
                end
                r = r2[DW-1:0];
            end
            rem_next[g] = r;
            quo_next[g] = q;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= rem_next[g];
                quo_reg[g] <= quo_next[g];
            end
        end
    end

    assign quo = quo_reg[NS-1];

endmodule

// ===== design/ltgi_blend.sv =====
// Blend of edge and corner values for one coordinate: U + W - UW.
`timescale 1ns / 1ps
module ltgi_blend #(
    parameter int CW = 32
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [ltgi_pkg::QBITS-1:0] xi,
    input  logic [ltgi_pkg::QBITS-1:0] zeta,
    input  logic signed [CW-1:0]       left_k,
    input  logic signed [CW-1:0]       right_k,
    input  logic signed [CW-1:0]       bottom_i,
    input  logic signed [CW-1:0]       top_i,
    input  logic signed [CW-1:0]       left_0,
    input  logic signed [CW-1:0]       left_h,
    input  logic signed [CW-1:0]       right_0,
    input  logic signed [CW-1:0]       right_h,
    output logic signed [CW+3:0]       total
);

    localparam int WB = ltgi_pkg::WBITS;
    localparam int QB = ltgi_pkg::QBITS;
    localparam int PW = CW + WB + 1;
    localparam int SW = CW + 4;

    logic [WB-1:0] a0, a1, c0, c1;
    logic [2*WB-1:0] m00, m01, m10, m11;

    // stage 1: edge products and corner weights
    logic signed [PW-1:0] pu0_reg, pu1_reg, pw0_reg, pw1_reg;
    logic [WB-1:0]        w00_reg, w01_reg, w10_reg, w11_reg;
    logic signed [CW-1:0] l0_reg, lh_reg, r0_reg, rh_reg;
    // stage 2: edge pair sums, corner products
    logic signed [SW-1:0] su_reg, sw_reg;
    logic signed [PW-1:0] pc00_reg, pc01_reg, pc10_reg, pc11_reg;
    // stage 3
    logic signed [SW-1:0] upw_reg, cpa_reg, cpb_reg;
    // stage 4
    logic signed [SW-1:0] total_reg;

    function automatic logic signed [PW-1:0] wprod(input logic [WB-1:0] w,
                                                   input logic signed [CW-1:0] c);
        logic signed [WB:0] ws;
        ws = $signed({1'b0, w});
        return ws * c;
    endfunction

    function automatic logic signed [SW-1:0] wterm(input logic signed [PW-1:0] p);
        return SW'(p >>> QB);
    endfunction

    always_comb
    begin
        a1  = {1'b0, xi};
        a0  = ltgi_pkg::ONE_Q16 - a1;
        c1  = {1'b0, zeta};
        c0  = ltgi_pkg::ONE_Q16 - c1;
        m00 = a0 * c0;
        m01 = a0 * c1;
        m10 = a1 * c0;
        m11 = a1 * c1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pu0_reg   <= wprod(a0, left_k);
            pu1_reg   <= wprod(a1, right_k);
            pw0_reg   <= wprod(c0, bottom_i);
            pw1_reg   <= wprod(c1, top_i);
            w00_reg   <= WB'(m00 >> QB);
            w01_reg   <= WB'(m01 >> QB);
            w10_reg   <= WB'(m10 >> QB);
            w11_reg   <= WB'(m11 >> QB);
            l0_reg    <= left_0;
            lh_reg    <= left_h;
            r0_reg    <= right_0;
            rh_reg    <= right_h;

            su_reg    <= wterm(pu0_reg) + wterm(pu1_reg);
            sw_reg    <= wterm(pw0_reg) + wterm(pw1_reg);
            pc00_reg  <= wprod(w00_reg, l0_reg);
            pc01_reg  <= wprod(w01_reg, lh_reg);
            pc10_reg  <= wprod(w10_reg, r0_reg);
            pc11_reg  <= wprod(w11_reg, rh_reg);

            upw_reg   <= su_reg + sw_reg;
            cpa_reg   <= wterm(pc00_reg) + wterm(pc01_reg);
            cpb_reg   <= wterm(pc10_reg) + wterm(pc11_reg);

            total_reg <= upw_reg - cpa_reg - cpb_reg;
        end
    end

    assign total = total_reg;

endmodule

// ===== design/linear_tfi_grid_interpolator_top.sv =====
// Top level of the linear transfinite grid interpolator.
`timescale 1ns / 1ps
// Usage:
//   Request channel (req_valid / req_stall / req_data) takes one request per
//   cycle while req_stall is low. A load request writes a boundary point into
//   the edge stores it lies on; an interpolate request names an interior point
//   (i,k) and returns x and z blended from the edges and the four corners.
//   Response channel (rsp_valid / rsp_stall / rsp_data) returns exactly one
//   response per request, in request order, with status loaded, interpolated,
//   bad index or saturated.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data) sets
//   grid width and height; cfg_ready is always high. Write only while no
//   request is in flight.
//   rsp_valid rises once the request has passed the entry register, 4 weight
//   divider stages, 4 multiply/add blend stages and the output register.
//   Throughput is one request per cycle while the response is not stalled.
//   Loads reach the edge stores at the stage where interpolations read them,
//   so every request sees exactly the loads accepted before it.
//   Reset clears all valid bits and sets both dimensions to 1024; edge store
//   contents are undefined until loaded.
//   A stalled response freezes the whole pipeline and holds req_stall high
//   until the response is taken.
module linear_tfi_grid_interpolator_top #(
    parameter int MAX_DIM     = 1024,
    parameter int COORD_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  ltgi_pkg::req_t                    req_data,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output ltgi_pkg::rsp_t                    rsp_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ltgi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ltgi_pkg::CFG_W-1:0]        cfg_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int SW   = CW + 4;
    localparam int AW   = $clog2(MAX_DIM);
    localparam int DW   = $clog2(MAX_DIM + 1);
    localparam int IW   = ltgi_pkg::IDX_IN_W;
    localparam int XW   = (DW > IW) ? DW : IW;
    localparam int LAT  = ltgi_pkg::LAT;
    localparam int RDS  = ltgi_pkg::DIV_STAGES;
    localparam int OUTW = ltgi_pkg::IO_COORD_W;

    logic [ltgi_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [DW-1:0]              eff_w, eff_h;
    logic                       en, accept;

    logic                       vld_reg [1:LAT];
    ltgi_pkg::ctl_t             ctl_reg [1:LAT-1];
    logic [IW-1:0]              col_reg [1:RDS];
    logic [IW-1:0]              row_reg [1:RDS];
    logic [3:0]                 wen_reg [1:RDS];
    logic [2*CW-1:0]            wdata_reg [1:RDS];

    logic [XW-1:0]              ie, ke, wd, hd;
    logic                       on_bnd, load_bad, interp_bad, load_ok;
    logic                       we_left, we_right, we_bottom, we_top;
    logic                       wr_left, wr_right, wr_bottom, wr_top;
    logic [AW-1:0]              waddr_k, waddr_i, raddr_k, raddr_i, raddr_h;
    logic [2*CW-1:0]            wdata;
    logic [2*CW-1:0]            lk, l0, lh, rk, r0, rh, bi, ti;
    logic [ltgi_pkg::QBITS-1:0] xi, zeta;
    logic signed [SW-1:0]       tot_x, tot_z;
    ltgi_pkg::rsp_t             rsp_reg, rsp_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ltgi_pkg::CFG_W'(1024);
            height_reg <= ltgi_pkg::CFG_W'(1024);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ltgi_pkg::CFG_GRID_WIDTH:  width_reg  <= cfg_data;
                ltgi_pkg::CFG_GRID_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp dimensions to the supported range
    always_comb
    begin
        if (width_reg < ltgi_pkg::CFG_W'(3))
            eff_w = DW'(3);
        else if (32'(width_reg) > MAX_DIM)
            eff_w = DW'(MAX_DIM);
        else
            eff_w = DW'(width_reg);
        if (height_reg < ltgi_pkg::CFG_W'(3))
            eff_h = DW'(3);
        else if (32'(height_reg) > MAX_DIM)
            eff_h = DW'(MAX_DIM);
        else
            eff_h = DW'(height_reg);
    end

    assign en        = !rsp_valid || !rsp_stall;
    assign req_stall = !en;
    assign accept    = req_valid && en;

    // index checks at entry
    always_comb
    begin
        ie         = XW'(req_data.col_index);
        ke         = XW'(req_data.row_index);
        wd         = XW'(eff_w);
        hd         = XW'(eff_h);
        on_bnd     = (ie == '0) || (ie == wd - 1'b1) || (ke == '0) || (ke == hd - 1'b1);
        load_bad   = (ie >= wd) || (ke >= hd) || !on_bnd;
        interp_bad = (ie == '0) || (ie > wd - 2'd2) || (ke == '0) || (ke > hd - 2'd2);
        load_ok    = accept && (req_data.req_type == ltgi_pkg::REQ_LOAD) && !load_bad;
        we_left    = load_ok && (ie == '0);
        we_right   = load_ok && (ie == wd - 1'b1);
        we_bottom  = load_ok && (ke == '0);
        we_top     = load_ok && (ke == hd - 1'b1);
        wdata      = {CW'($unsigned(req_data.coord_z)), CW'($unsigned(req_data.coord_x))};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= LAT; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
            for (int s = 1; s <= RDS; s++)
            begin
                wen_reg[s] <= '0;
            end
        end
        else if (en)
        begin
            vld_reg[1] <= req_valid;
            for (int s = 2; s <= LAT; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
            wen_reg[1] <= {we_top, we_bottom, we_right, we_left};
            for (int s = 2; s <= RDS; s++)
            begin
                wen_reg[s] <= wen_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg[1].interp <= (req_data.req_type == ltgi_pkg::REQ_INTERP);
            ctl_reg[1].bad    <= (req_data.req_type == ltgi_pkg::REQ_INTERP) ?
                                 interp_bad : load_bad;
            col_reg[1]        <= req_data.col_index;
            row_reg[1]        <= req_data.row_index;
            wdata_reg[1]      <= wdata;
            for (int s = 2; s <= LAT - 1; s++)
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
            for (int s = 2; s <= RDS; s++)
            begin
                col_reg[s]   <= col_reg[s-1];
                row_reg[s]   <= row_reg[s-1];
                wdata_reg[s] <= wdata_reg[s-1];
            end
        end
    end

    ltgi_div #(.DW(DW)) u_div_x (
        .clk (clk),
        .en  (en),
        .num (DW'(col_reg[1])),
        .den (eff_w - 1'b1),
        .quo (xi)
    );

    ltgi_div #(.DW(DW)) u_div_z (
        .clk (clk),
        .en  (en),
        .num (DW'(row_reg[1])),
        .den (eff_h - 1'b1),
        .quo (zeta)
    );

    // edge reads line up with the divider output
    assign raddr_k = AW'(row_reg[RDS]);
    assign raddr_i = AW'(col_reg[RDS]);
    assign raddr_h = AW'(eff_h - 1'b1);

    // commit loads at the read stage so requests see stores in order
    assign waddr_k   = raddr_k;
    assign waddr_i   = raddr_i;
    assign wr_left   = en && wen_reg[RDS][0];
    assign wr_right  = en && wen_reg[RDS][1];
    assign wr_bottom = en && wen_reg[RDS][2];
    assign wr_top    = en && wen_reg[RDS][3];

    ltgi_ram #(.DEPTH(MAX_DIM), .AW(AW), .DWID(2*CW)) u_left_k (
        .clk(clk), .we(wr_left), .waddr(waddr_k), .wdata(wdata_reg[RDS]),
        .re(en), .raddr(raddr_k), .rdata(lk)
    );
    ltgi_ram #(.DEPTH(MAX_DIM), .AW(AW), .DWID(2*CW)) u_left_0 (
        .clk(clk), .we(wr_left), .waddr(waddr_k), .wdata(wdata_reg[RDS]),
        .re(en), .raddr(AW'(0)), .rdata(l0)
    );
    ltgi_ram #(.DEPTH(MAX_DIM), .AW(AW), .DWID(2*CW)) u_left_h (
        .clk(clk), .we(wr_left), .waddr(waddr_k), .wdata(wdata_reg[RDS]),
        .re(en), .raddr(raddr_h), .rdata(lh)
    );
    ltgi_ram #(.DEPTH(MAX_DIM), .AW(AW), .DWID(2*CW)) u_right_k (
        .clk(clk), .we(wr_right), .waddr(waddr_k), .wdata(wdata_reg[RDS]),
        .re(en), .raddr(raddr_k), .rdata(rk)
    );
    ltgi_ram #(.DEPTH(MAX_DIM), .AW(AW), .DWID(2*CW)) u_right_0 (
        .clk(clk), .we(wr_right), .waddr(waddr_k), .wdata(wdata_reg[RDS]),
        .re(en), .raddr(AW'(0)), .rdata(r0)
    );
    ltgi_ram #(.DEPTH(MAX_DIM), .AW(AW), .DWID(2*CW)) u_right_h (
        .clk(clk), .we(wr_right), .waddr(waddr_k), .wdata(wdata_reg[RDS]),
        .re(en), .raddr(raddr_h), .rdata(rh)
    );
    ltgi_ram #(.DEPTH(MAX_DIM), .AW(AW), .DWID(2*CW)) u_bottom (
        .clk(clk), .we(wr_bottom), .waddr(waddr_i), .wdata(wdata_reg[RDS]),
        .re(en), .raddr(raddr_i), .rdata(bi)
    );
    ltgi_ram #(.DEPTH(MAX_DIM), .AW(AW), .DWID(2*CW)) u_top (
        .clk(clk), .we(wr_top), .waddr(waddr_i), .wdata(wdata_reg[RDS]),
        .re(en), .raddr(raddr_i), .rdata(ti)
    );

    ltgi_blend #(.CW(CW)) u_blend_x (
        .clk      (clk),
        .en       (en),
        .xi       (xi),
        .zeta     (zeta),
        .left_k   ($signed(lk[CW-1:0])),
        .right_k  ($signed(rk[CW-1:0])),
        .bottom_i ($signed(bi[CW-1:0])),
        .top_i    ($signed(ti[CW-1:0])),
        .left_0   ($signed(l0[CW-1:0])),
        .left_h   ($signed(lh[CW-1:0])),
        .right_0  ($signed(r0[CW-1:0])),
        .right_h  ($signed(rh[CW-1:0])),
        .total    (tot_x)
    );

    ltgi_blend #(.CW(CW)) u_blend_z (
        .clk      (clk),
        .en       (en),
        .xi       (xi),
        .zeta     (zeta),
        .left_k   ($signed(lk[2*CW-1:CW])),
        .right_k  ($signed(rk[2*CW-1:CW])),
        .bottom_i ($signed(bi[2*CW-1:CW])),
        .top_i    ($signed(ti[2*CW-1:CW])),
        .left_0   ($signed(l0[2*CW-1:CW])),
        .left_h   ($signed(lh[2*CW-1:CW])),
        .right_0  ($signed(r0[2*CW-1:CW])),
        .right_h  ($signed(rh[2*CW-1:CW])),
        .total    (tot_z)
    );

    // saturate and pick the response
    always_comb
    begin
        logic              hi_x, lo_x, hi_z, lo_z;
        logic [CW-1:0]     vx, vz;
        logic signed [SW-1:0] cmax, cmin;
        cmax = $signed({{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}});
        cmin = $signed({{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}});
        hi_x = tot_x > cmax;
        lo_x = tot_x < cmin;
        hi_z = tot_z > cmax;
        lo_z = tot_z < cmin;
        vx   = hi_x ? {1'b0, {(CW-1){1'b1}}} : lo_x ? {1'b1, {(CW-1){1'b0}}} : tot_x[CW-1:0];
        vz   = hi_z ? {1'b0, {(CW-1){1'b1}}} : lo_z ? {1'b1, {(CW-1){1'b0}}} : tot_z[CW-1:0];
        rsp_next.out_x  = '0;
        rsp_next.out_z  = '0;
        rsp_next.status = ltgi_pkg::ST_BAD;
        if (!ctl_reg[LAT-1].bad)
        begin
            if (ctl_reg[LAT-1].interp)
            begin
                rsp_next.out_x  = OUTW'($unsigned(vx));
                rsp_next.out_z  = OUTW'($unsigned(vz));
                rsp_next.status = (hi_x || lo_x || hi_z || lo_z) ?
                                  ltgi_pkg::ST_SAT : ltgi_pkg::ST_INTERP;
            end
            else
            begin
                rsp_next.status = ltgi_pkg::ST_LOADED;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = vld_reg[LAT];
    assign rsp_data  = rsp_reg;

    // a load or a bad index never carries coordinates
    a_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status == ltgi_pkg::ST_LOADED ||
                      rsp_data.status == ltgi_pkg::ST_BAD)
        |-> rsp_data.out_x == '0 && rsp_data.out_z == '0)
        else $error("load or bad response with nonzero coordinates");

    // saturated status means at least one coordinate sits at a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == ltgi_pkg::ST_SAT
        |-> rsp_data.out_x == OUTW'({1'b0, {(CW-1){1'b1}}}) ||
            rsp_data.out_x == OUTW'({1'b1, {(CW-1){1'b0}}}) ||
            rsp_data.out_z == OUTW'({1'b0, {(CW-1){1'b1}}}) ||
            rsp_data.out_z == OUTW'({1'b1, {(CW-1){1'b0}}}))
        else $error("saturated response without a clamped coordinate");

    // a frozen pipeline keeps its valid bits in place
    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> vld_reg[1] == $past(vld_reg[1]) &&
                vld_reg[LAT/2] == $past(vld_reg[LAT/2]) &&
                vld_reg[LAT-1] == $past(vld_reg[LAT-1]))
        else $error("pipeline moved during stall");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the linear transfinite grid interpolator.
`timescale 1ns / 1ps
module testbench;

    localparam int DIM = 1024;
    localparam int EDGE_LEFT   = 0;
    localparam int EDGE_RIGHT  = 1;
    localparam int EDGE_BOTTOM = 2;
    localparam int EDGE_TOP    = 3;
    localparam longint CMAX = 64'sd2147483647;
    localparam longint CMIN = -64'sd2147483648;

    logic                           clk;
    logic                           rst_n;
    logic                           req_valid;
    logic                           req_stall;
    ltgi_pkg::req_t                 req_data;
    logic                           rsp_valid;
    logic                           rsp_stall;
    ltgi_pkg::rsp_t                 rsp_data;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [ltgi_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ltgi_pkg::CFG_W-1:0]     cfg_data;

    linear_tfi_grid_interpolator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [ltgi_pkg::CFG_W-1:0] width_reg;
    logic [ltgi_pkg::CFG_W-1:0] height_reg;
    longint           edge_x [4][DIM];
    longint           edge_z [4][DIM];
    bit               edge_set [4][DIM];

    ltgi_pkg::rsp_t pending_q[$];
    int   errors;
    int   sent;
    int   burst_left;
    int   stall_left;
    int   stall_mode;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    function automatic int eff_dim(logic [ltgi_pkg::CFG_W-1:0] r);
        if (r < 3)
            return 3;
        if (r > DIM)
            return DIM;
        return int'(r);
    endfunction

    // floor(w * c / 2^16)
    function automatic longint weigh(longint w, longint c);
        return (w * c) >>> ltgi_pkg::QBITS;
    endfunction

    function automatic longint clamp_coord(longint v, inout bit hit);
        if (v > CMAX)
        begin
            hit = 1'b1;
            return CMAX;
        end
        if (v < CMIN)
        begin
            hit = 1'b1;
            return CMIN;
        end
        return v;
    endfunction

    function automatic longint blend_axis(bit zaxis, int i, int k, int ht,
                                          longint a0, longint a1,
                                          longint c0, longint c1);
        longint u;
        longint w;
        longint uw;
        longint l_k;
        longint r_k;
        longint b_i;
        longint t_i;
        longint l0;
        longint lh;
        longint r0;
        longint rh;
        l_k = zaxis ? edge_z[EDGE_LEFT][k]     : edge_x[EDGE_LEFT][k];
        r_k = zaxis ? edge_z[EDGE_RIGHT][k]    : edge_x[EDGE_RIGHT][k];
        b_i = zaxis ? edge_z[EDGE_BOTTOM][i]   : edge_x[EDGE_BOTTOM][i];
        t_i = zaxis ? edge_z[EDGE_TOP][i]      : edge_x[EDGE_TOP][i];
        l0  = zaxis ? edge_z[EDGE_LEFT][0]     : edge_x[EDGE_LEFT][0];
        lh  = zaxis ? edge_z[EDGE_LEFT][ht-1]  : edge_x[EDGE_LEFT][ht-1];
        r0  = zaxis ? edge_z[EDGE_RIGHT][0]    : edge_x[EDGE_RIGHT][0];
        rh  = zaxis ? edge_z[EDGE_RIGHT][ht-1] : edge_x[EDGE_RIGHT][ht-1];
        u  = weigh(a0, l_k) + weigh(a1, r_k);
        w  = weigh(c0, b_i) + weigh(c1, t_i);
        uw = weigh((a0 * c0) >> ltgi_pkg::QBITS, l0) + weigh((a0 * c1) >> ltgi_pkg::QBITS, lh)
           + weigh((a1 * c0) >> ltgi_pkg::QBITS, r0) + weigh((a1 * c1) >> ltgi_pkg::QBITS, rh);
        return u + w - uw;
    endfunction

    function automatic void store_point(int e, int n, ltgi_pkg::req_t r);
        edge_x[e][n]   = longint'(r.coord_x);
        edge_z[e][n]   = longint'(r.coord_z);
        edge_set[e][n] = 1'b1;
    endfunction

    function automatic ltgi_pkg::rsp_t predict_point(ltgi_pkg::req_t r);
        ltgi_pkg::rsp_t e;
        int     wd;
        int     ht;
        int     i;
        int     k;
        longint a0;
        longint a1;
        longint c0;
        longint c1;
        longint vx;
        longint vz;
        bit     hit;
        wd = eff_dim(width_reg);
        ht = eff_dim(height_reg);
        i = int'(r.col_index);
        k = int'(r.row_index);
        e.out_x = '0;
        e.out_z = '0;
        e.status = ltgi_pkg::ST_BAD;
        hit = 1'b0;
        if (r.req_type == ltgi_pkg::REQ_LOAD)
        begin
            if (i < wd && k < ht && (i == 0 || i == wd-1 || k == 0 || k == ht-1))
            begin
                if (i == 0)
                    store_point(EDGE_LEFT, k, r);
                if (i == wd-1)
                    store_point(EDGE_RIGHT, k, r);
                if (k == 0)
                    store_point(EDGE_BOTTOM, i, r);
                if (k == ht-1)
                    store_point(EDGE_TOP, i, r);
                e.status = ltgi_pkg::ST_LOADED;
            end
        end
        else if (i >= 1 && i <= wd-2 && k >= 1 && k <= ht-2)
        begin
            a1 = (longint'(i) << ltgi_pkg::QBITS) / (wd - 1);
            c1 = (longint'(k) << ltgi_pkg::QBITS) / (ht - 1);
            a0 = (longint'(1) << ltgi_pkg::QBITS) - a1;
            c0 = (longint'(1) << ltgi_pkg::QBITS) - c1;
            vx = clamp_coord(blend_axis(1'b0, i, k, ht, a0, a1, c0, c1), hit);
            vz = clamp_coord(blend_axis(1'b1, i, k, ht, a0, a1, c0, c1), hit);
            e.out_x = vx[31:0];
            e.out_z = vz[31:0];
            e.status = hit ? ltgi_pkg::ST_SAT : ltgi_pkg::ST_INTERP;
        end
        return e;
    endfunction

    // receiver: stall on a random pattern that switches between four modes
    always @(posedge clk)
    begin
        if (stall_left <= 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 300);
        end
        stall_left--;
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 1);
            default: rsp_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        ltgi_pkg::rsp_t exp_rsp;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected response x=%h z=%h st=%0d",
                             rsp_data.out_x, rsp_data.out_z, rsp_data.status);
            end
            else
            begin
                exp_rsp = pending_q.pop_front();
                if (rsp_data.out_x !== exp_rsp.out_x || rsp_data.out_z !== exp_rsp.out_z
                    || rsp_data.status !== exp_rsp.status)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp x=%h z=%h st=%0d, got x=%h z=%h st=%0d",
                                 exp_rsp.out_x, exp_rsp.out_z, exp_rsp.status,
                                 rsp_data.out_x, rsp_data.out_z, rsp_data.status);
                end
            end
        end
    end

    task automatic send_req(ltgi_pkg::req_t r);
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall);
        pending_q.push_back(predict_point(r));
        sent++;
        if (burst_left <= 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
        else
            burst_left--;
    endtask

    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom;
            3: return $urandom;
            default: return $signed($urandom_range(0, 32'h07ff_ffff)) - 32'sh0400_0000;
        endcase
    endfunction

    task automatic load_point(int i, int k, logic signed [31:0] x, logic signed [31:0] z);
        ltgi_pkg::req_t r;
        r.req_type  = ltgi_pkg::REQ_LOAD;
        r.col_index = i[ltgi_pkg::IDX_IN_W-1:0];
        r.row_index = k[ltgi_pkg::IDX_IN_W-1:0];
        r.coord_x   = x;
        r.coord_z   = z;
        send_req(r);
    endtask

    task automatic interp_raw(int i, int k);
        ltgi_pkg::req_t r;
        r.req_type  = ltgi_pkg::REQ_INTERP;
        r.col_index = i[ltgi_pkg::IDX_IN_W-1:0];
        r.row_index = k[ltgi_pkg::IDX_IN_W-1:0];
        r.coord_x   = $urandom;
        r.coord_z   = $urandom;
        send_req(r);
    endtask

    // load whatever boundary entries the point still lacks, then query it
    task automatic interp_point(int i, int k);
        int wd;
        int ht;
        wd = eff_dim(width_reg);
        ht = eff_dim(height_reg);
        if (!edge_set[EDGE_LEFT][0])
            load_point(0, 0, pick_coord(), pick_coord());
        if (!edge_set[EDGE_LEFT][ht-1])
            load_point(0, ht-1, pick_coord(), pick_coord());
        if (!edge_set[EDGE_RIGHT][0])
            load_point(wd-1, 0, pick_coord(), pick_coord());
        if (!edge_set[EDGE_RIGHT][ht-1])
            load_point(wd-1, ht-1, pick_coord(), pick_coord());
        if (!edge_set[EDGE_LEFT][k])
            load_point(0, k, pick_coord(), pick_coord());
        if (!edge_set[EDGE_RIGHT][k])
            load_point(wd-1, k, pick_coord(), pick_coord());
        if (!edge_set[EDGE_BOTTOM][i])
            load_point(i, 0, pick_coord(), pick_coord());
        if (!edge_set[EDGE_TOP][i])
            load_point(i, ht-1, pick_coord(), pick_coord());
        interp_raw(i, k);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (ltgi_pkg::LAT + 4) @(posedge clk);
    endtask

    task automatic cfg_write(logic [ltgi_pkg::CFG_IDX_W-1:0] idx,
                             logic [ltgi_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == ltgi_pkg::CFG_GRID_WIDTH)
            width_reg = val;
        else
            height_reg = val;
    endtask

    task automatic test_default_grid();
        load_point(0, 0, 32'sh0001_0000, 32'sh0002_0000);
        load_point(1023, 1023, 32'sh7fffffff, 32'sh80000000);
        load_point(512, 512, 32'sh1234_5678, 32'sh0);
        interp_point(1, 1);
        interp_point(1022, 1022);
        interp_raw(0, 5);
        interp_raw(1023, 5);
        interp_raw(5, 0);
        interp_raw(5, 1023);
        wait_idle();
    endtask

    task automatic test_min_grid();
        cfg_write(ltgi_pkg::CFG_GRID_WIDTH, 11'd0);
        cfg_write(ltgi_pkg::CFG_GRID_HEIGHT, 11'd2);
        // corners at the minimum, midpoints at the maximum: sum overflows high
        load_point(0, 0, 32'sh80000000, 32'sh80000000);
        load_point(2, 0, 32'sh80000000, 32'sh0);
        load_point(0, 2, 32'sh80000000, 32'sh0);
        load_point(2, 2, 32'sh80000000, 32'sh0);
        load_point(0, 1, 32'sh7fffffff, 32'sh0001_0000);
        load_point(2, 1, 32'sh7fffffff, 32'sh0001_0000);
        load_point(1, 0, 32'sh7fffffff, 32'sh0001_0000);
        load_point(1, 2, 32'sh7fffffff, 32'sh0001_0000);
        interp_raw(1, 1);
        load_point(1, 1, 32'sh1, 32'sh1);
        load_point(3, 0, 32'sh1, 32'sh1);
        load_point(0, 1023, 32'sh1, 32'sh1);
        interp_raw(2, 1);
        interp_raw(1, 2);
        wait_idle();
    endtask

    task automatic run_phase(logic [ltgi_pkg::CFG_W-1:0] w, logic [ltgi_pkg::CFG_W-1:0] h,
                             int quota);
        int wd;
        int ht;
        int stop_at;
        int i;
        int k;
        cfg_write(ltgi_pkg::CFG_GRID_WIDTH, w);
        cfg_write(ltgi_pkg::CFG_GRID_HEIGHT, h);
        wd = eff_dim(width_reg);
        ht = eff_dim(height_reg);
        stop_at = sent + quota;
        while (sent < stop_at)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                    interp_point($urandom_range(1, wd-2), $urandom_range(1, ht-2));
                6:
                begin
                    i = $urandom_range(0, 1023);
                    k = $urandom_range(0, 1023);
                    if ($urandom_range(0, 1))
                        i = ($urandom_range(0, 1)) ? 0 : wd - 1;
                    if (i >= 1 && i <= wd-2 && k >= 1 && k <= ht-2)
                        interp_point(i, k);
                    else
                        interp_raw(i, k);
                end
                7, 8:
                begin
                    case ($urandom_range(0, 3))
                        0: load_point(0, $urandom_range(0, ht-1), pick_coord(), pick_coord());
                        1: load_point(wd-1, $urandom_range(0, ht-1), pick_coord(), pick_coord());
                        2: load_point($urandom_range(0, wd-1), 0, pick_coord(), pick_coord());
                        default: load_point($urandom_range(0, wd-1), ht-1,
                                            pick_coord(), pick_coord());
                    endcase
                end
                default:
                    load_point($urandom_range(0, 1023), $urandom_range(0, 1023),
                               $urandom, $urandom);
            endcase
        end
        wait_idle();
    endtask

    task automatic test_random_grids();
        run_phase(11'd1024, 11'd1024, 200);
        run_phase(11'd3, 11'd3, 150);
        run_phase(11'd2047, 11'd1, 150);
        run_phase(11'd5, 11'd1500, 150);
        run_phase(11'd16, 11'd9, 250);
        // random grids of 4 to 40 per side, each phase drained before the next
        run_phase(11'($urandom_range(4, 40)), 11'($urandom_range(4, 40)), 120);
        run_phase(11'($urandom_range(4, 40)), 11'($urandom_range(4, 40)), 200);
        run_phase(11'd1024, 11'd1023, 100);
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        req_data   <= '0;
        rsp_stall  <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        width_reg  = 11'd1024;
        height_reg = 11'd1024;
        errors     = 0;
        sent       = 0;
        burst_left = 0;
        stall_left = 0;
        stall_mode = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_grid();
        test_min_grid();
        test_random_grids();
        wait_idle();

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
